/* sv/bcdtod_pkg.sv */
// Package for the BCD time-of-day shift core: beat types and constants.
// Used by bcd_time_of_day_shift_core and bcdtod_checker; no dependencies.
package bcdtod_pkg;

  // One input beat: current time, sub-second count and requested shift
  typedef struct packed {
    logic [22:0]        time_bcd;
    logic [7:0]         subsecond_down;
    logic signed [31:0] offset_ms;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic               write_time;
    logic [21:0]        new_time_bcd;
    logic signed [31:0] applied_offset_ms;
  } out_beat_t;

  // Pipeline depth from input register to output register
  localparam int NUM_STAGES = 11;

  // Time constants
  localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
  localparam logic [8:0]  HALF_SEC_MS   = 9'd500;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic [3:0]  DEC_BASE      = 4'd10;
  localparam logic [7:0]  SUBSEC_TOP    = 8'd255;

  // Reciprocals for division by constants
  // n / 1000 = (n * RECIP_MS) >> 38, exact for any 32-bit n
  localparam logic [28:0] RECIP_MS      = 29'd274877907;
  // a / 675 = (a * RECIP_675) >> 25, exact for a < 2^16
  localparam logic [15:0] RECIP_675     = 16'd49711;
  // a / 225 = (a * RECIP_225) >> 20, exact for a < 5400
  localparam logic [12:0] RECIP_225     = 13'd4661;
  // a / 15 = (a * RECIP_15) >> 14, exact for a < 1024
  localparam logic [10:0] RECIP_15      = 11'd1093;
  // a / 10 = (a * RECIP_10) >> 11, exact for a < 1029
  localparam logic [7:0]  RECIP_10      = 8'd205;

endpackage

/* sv/bcd_time_of_day_shift_core.sv */
// Top level of the BCD time-of-day shift core: an eleven-stage pipeline.
// Depends on bcdtod_pkg for beat types, time constants and reciprocals.
//
// Usage:
//   The item channel (item_valid, item_stall, item) takes one beat per
//   cycle: a packed BCD time, the 256 Hz sub-second down-count and a signed
//   shift in ms. The result channel (result_valid, result_stall, result)
//   returns exactly one beat per item, in order: write_time, the shifted
//   time rounded to whole seconds in the same BCD layout, and the applied
//   shift (new minus old, in ms). The cfg channel writes clock_ready; it
//   is always ready and must only be written while the core is idle.
//   When clock_ready is 0 or the shift is 0 the result is all zeros.
// Pipeline and throughput:
//   An item passes eleven register stages, the first loaded at the edge
//   that accepts it; one item per cycle is sustained while result_stall
//   is low. The stages run time to ms, ms add and magnitude, reciprocal
//   divide by 1000, day wrap, and the hour/minute/digit split, each with
//   its multiplier behind a register.
// Reset and stall:
//   rst (synchronous) empties the pipeline and clears clock_ready. When
//   result_stall is high the output beat holds; earlier stages keep
//   advancing into empty slots, and item_stall rises once no slot is free.
module bcd_time_of_day_shift_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  bcdtod_pkg::in_beat_t  item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output bcdtod_pkg::out_beat_t result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);
  import bcdtod_pkg::*;

  logic                  clock_ready;
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] adv;

  // Stage 1: seconds of day and sub-second fraction
  logic        s1_act;
  logic [17:0] s1_tot;
  logic [9:0]  s1_frac;
  logic [31:0] s1_shift;
  // Stage 2: old time in ms
  logic        s2_act;
  logic [27:0] s2_old;
  logic [31:0] s2_shift;
  // Stage 3: rounded target, sign and magnitude
  logic        s3_act;
  logic [27:0] s3_old;
  logic        s3_neg;
  logic [31:0] s3_mag;
  // Stage 4: whole-second magnitude
  logic        s4_act;
  logic [27:0] s4_old;
  logic        s4_neg;
  logic [22:0] s4_q;
  // Stage 5: day count and new ms
  logic        s5_act;
  logic [27:0] s5_old;
  logic        s5_neg;
  logic [22:0] s5_q;
  logic [6:0]  s5_days;
  logic [31:0] s5_new_ms;
  // Stage 6: second of day and applied shift
  logic        s6_act;
  logic [16:0] s6_sod;
  logic [31:0] s6_diff;
  // Stage 7: hours
  logic        s7_act;
  logic [16:0] s7_sod;
  logic [4:0]  s7_hr;
  logic [31:0] s7_diff;
  // Stage 8: seconds within the hour
  logic        s8_act;
  logic [4:0]  s8_hr;
  logic [11:0] s8_rem;
  logic [31:0] s8_diff;
  // Stage 9: minutes
  logic        s9_act;
  logic [4:0]  s9_hr;
  logic [11:0] s9_rem;
  logic [5:0]  s9_mn;
  logic [31:0] s9_diff;
  // Stage 10: seconds, hour and minute tens
  logic        s10_act;
  logic [4:0]  s10_hr;
  logic [5:0]  s10_mn;
  logic [5:0]  s10_sc;
  logic [1:0]  s10_ht;
  logic [2:0]  s10_mt;
  logic [31:0] s10_diff;

  // Combinational stage values
  logic [5:0]  c1_h;
  logic [6:0]  c1_m;
  logic [6:0]  c1_s;
  logic [17:0] c1_frac_full;
  logic [33:0] c3_x;
  logic [63:0] c4_prod;
  logic [31:0] c5_sec;
  logic [31:0] c5_prod;
  logic [22:0] c6_day_sec;
  logic [16:0] c6_rem;
  logic [24:0] c7_prod;
  logic [16:0] c8_hsec;
  logic [19:0] c9_prod;
  logic [11:0] c10_msec;
  logic [12:0] c10_hprod;
  logic [13:0] c10_mprod;
  logic [13:0] c11_sprod;
  logic [2:0]  c11_st;
  logic [3:0]  c11_hu;
  logic [3:0]  c11_mu;
  logic [3:0]  c11_su;
  logic [6:0]  c11_htx;
  logic [6:0]  c11_mtx;
  logic [6:0]  c11_stx;
  logic [21:0] c11_bcd;

  // Config register: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ready <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      clock_ready <= cfg_data;
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NUM_STAGES-1] = !v[NUM_STAGES-1] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign item_stall   = !adv[0];
  assign result_valid = v[NUM_STAGES-1];

  // Move valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= item_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: decode BCD digits, sum seconds, scale the fraction
  always_comb begin
    c1_h = 6'(item.time_bcd[21:20]) * 6'(DEC_BASE) + 6'(item.time_bcd[19:16]);
    c1_m = 7'(item.time_bcd[14:12]) * 7'(DEC_BASE) + 7'(item.time_bcd[11:8]);
    c1_s = 7'(item.time_bcd[6:4]) * 7'(DEC_BASE) + 7'(item.time_bcd[3:0]);
    c1_frac_full = 18'(SUBSEC_TOP - item.subsecond_down) * 18'(MS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_act   <= clock_ready && (item.offset_ms != '0);
      s1_tot   <= 18'(c1_h) * 18'(SEC_PER_HOUR) + 18'(c1_m) * 18'(SEC_PER_MIN)
                  + 18'(c1_s);
      s1_frac  <= c1_frac_full[17:8];
      s1_shift <= item.offset_ms;
    end
  end

  // Stage 2: old time in ms
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_act   <= s1_act;
      s2_old   <= 28'(s1_tot) * 28'(MS_PER_SEC) + 28'(s1_frac);
      s2_shift <= s1_shift;
    end
  end

  // Stage 3: add shift and half second, split into sign and magnitude
  assign c3_x = {6'b0, s2_old} + {{2{s2_shift[31]}}, s2_shift} + 34'(HALF_SEC_MS);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_act <= s2_act;
      s3_old <= s2_old;
      s3_neg <= c3_x[33];
      s3_mag <= c3_x[33] ? 32'(-c3_x) : c3_x[31:0];
    end
  end

  // Stage 4: truncate magnitude to whole seconds
  assign c4_prod = 64'(s3_mag) * 64'(RECIP_MS);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_act <= s3_act;
      s4_old <= s3_old;
      s4_neg <= s3_neg;
      s4_q   <= c4_prod[60:38];
    end
  end

  // Stage 5: count whole days, restore sign, scale back to ms
  assign c5_sec  = s4_neg ? -{9'b0, s4_q} : {9'b0, s4_q};
  assign c5_prod = 32'(s4_q[22:7]) * 32'(RECIP_675);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_act    <= s4_act;
      s5_old    <= s4_old;
      s5_neg    <= s4_neg;
      s5_q      <= s4_q;
      s5_days   <= c5_prod[31:25];
      s5_new_ms <= c5_sec * 32'(MS_PER_SEC);
    end
  end

  // Stage 6: wrap into one day with a non-negative remainder
  assign c6_day_sec = 23'(s5_days) * 23'(SEC_PER_DAY);
  assign c6_rem     = 17'(s5_q - c6_day_sec);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_act  <= s5_act;
      s6_sod  <= (s5_neg && (c6_rem != '0)) ? SEC_PER_DAY - c6_rem : c6_rem;
      s6_diff <= s5_new_ms - {4'b0, s5_old};
    end
  end

  // Stage 7: hours
  assign c7_prod = 25'(s6_sod[16:4]) * 25'(RECIP_225);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_act  <= s6_act;
      s7_sod  <= s6_sod;
      s7_hr   <= c7_prod[24:20];
      s7_diff <= s6_diff;
    end
  end

  // Stage 8: seconds within the hour
  assign c8_hsec = 17'(s7_hr) * 17'(SEC_PER_HOUR);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_act  <= s7_act;
      s8_hr   <= s7_hr;
      s8_rem  <= 12'(s7_sod - c8_hsec);
      s8_diff <= s7_diff;
    end
  end

  // Stage 9: minutes
  assign c9_prod = 20'(s8_rem[11:2]) * 20'(RECIP_15);

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s9_act  <= s8_act;
      s9_hr   <= s8_hr;
      s9_rem  <= s8_rem;
      s9_mn   <= c9_prod[19:14];
      s9_diff <= s8_diff;
    end
  end

  // Stage 10: seconds, tens of hours and minutes
  assign c10_msec  = 12'(s9_mn) * 12'(SEC_PER_MIN);
  assign c10_hprod = 13'(s9_hr) * 13'(RECIP_10);
  assign c10_mprod = 14'(s9_mn) * 14'(RECIP_10);

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s10_act  <= s9_act;
      s10_hr   <= s9_hr;
      s10_mn   <= s9_mn;
      s10_sc   <= 6'(s9_rem - c10_msec);
      s10_ht   <= c10_hprod[12:11];
      s10_mt   <= c10_mprod[13:11];
      s10_diff <= s9_diff;
    end
  end

  // Stage 11: units digits, pack BCD, zero the beat when nothing shifts
  always_comb begin
    c11_sprod = 14'(s10_sc) * 14'(RECIP_10);
    c11_st    = c11_sprod[13:11];
    c11_htx   = 7'(s10_ht) * 7'(DEC_BASE);
    c11_mtx   = 7'(s10_mt) * 7'(DEC_BASE);
    c11_stx   = 7'(c11_st) * 7'(DEC_BASE);
    c11_hu    = 4'(7'(s10_hr) - c11_htx);
    c11_mu    = 4'(7'(s10_mn) - c11_mtx);
    c11_su    = 4'(7'(s10_sc) - c11_stx);
    c11_bcd   = {s10_ht, c11_hu, 1'b0, s10_mt, c11_mu, 1'b0, c11_st, c11_su};
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      result.write_time        <= s10_act;
      result.new_time_bcd      <= s10_act ? c11_bcd : '0;
      result.applied_offset_ms <= s10_act ? s10_diff : '0;
    end
  end

endmodule

/* sv/bcdtod_checker.sv */
// Port-level checker for bcd_time_of_day_shift_core, with its bind.
// Depends on bcdtod_pkg for the beat types.
module bcdtod_props (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_stall,
  input bcdtod_pkg::out_beat_t result
);
  import bcdtod_pkg::*;

  // Hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Drop the payload of a beat that writes nothing
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_time |->
      (result.new_time_bcd == '0) && (result.applied_offset_ms == '0))
    else $error("no-write beat carries a nonzero payload");

  // Emit only legal time-of-day digits on a write
  a_legal_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_time |->
      (result.new_time_bcd[21:20] <= 2'd2) && (result.new_time_bcd[19:16] <= 4'd9) &&
      ((result.new_time_bcd[21:20] != 2'd2) || (result.new_time_bcd[19:16] <= 4'd3)) &&
      !result.new_time_bcd[15] && (result.new_time_bcd[14:12] <= 3'd5) &&
      (result.new_time_bcd[11:8] <= 4'd9) && !result.new_time_bcd[7] &&
      (result.new_time_bcd[6:4] <= 3'd5) && (result.new_time_bcd[3:0] <= 4'd9))
    else $error("written time is not a legal time of day");

  // Empty the result channel at reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind bcd_time_of_day_shift_core bcdtod_props u_bcdtod_props (.*);

/* verif/bcdtod_checker.sv */
// Checker for the BCD time-of-day shift core: watches the item, result and cfg channels,
// predicts each result beat and compares it field by field with what the core returns.
// Depends on bcdtod_pkg for the beat types.
`timescale 1ns / 1ps

module bcdtod_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  bcdtod_pkg::in_beat_t  item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  bcdtod_pkg::out_beat_t result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_data,
  output int                    errors,
  output int                    due_count
);
  import bcdtod_pkg::*;

  localparam longint DAY_S  = 86400;
  localparam longint HOUR_S = 3600;
  localparam longint MIN_S  = 60;
  localparam longint SEC_MS = 1000;
  localparam longint HALF_MS = 500;

  bit        clock_on;
  out_beat_t due_times[$];

  // Shift one time word and round it to whole seconds
  function automatic out_beat_t shifted_time(in_beat_t b, bit running);
    out_beat_t r;
    longint hrs, mins, secs, frac, old_ms, total, whole, day_sec, diff;
    longint nh, nm, ns;
    r = '0;
    if (!running || b.offset_ms == 0) return r;
    // Digits are taken at face value, even above nine
    hrs  = longint'(b.time_bcd[21:20]) * 10 + longint'(b.time_bcd[19:16]);
    mins = longint'(b.time_bcd[14:12]) * 10 + longint'(b.time_bcd[11:8]);
    secs = longint'(b.time_bcd[6:4]) * 10 + longint'(b.time_bcd[3:0]);
    frac = ((255 - longint'(b.subsecond_down)) * SEC_MS) >> 8;
    old_ms = (hrs * HOUR_S + mins * MIN_S + secs) * SEC_MS + frac;
    total = old_ms + longint'($signed(b.offset_ms));
    // Division truncates toward zero, so negative sums round toward zero
    whole = (total + HALF_MS) / SEC_MS;
    day_sec = ((whole % DAY_S) + DAY_S) % DAY_S;
    nh = day_sec / HOUR_S;
    nm = (day_sec % HOUR_S) / MIN_S;
    ns = day_sec % MIN_S;
    diff = whole * SEC_MS - old_ms;
    r.write_time = 1'b1;
    r.new_time_bcd = 22'(((nh / 10) << 20) | ((nh % 10) << 16) | ((nm / 10) << 12) |
                         ((nm % 10) << 8) | ((ns / 10) << 4) | (ns % 10));
    r.applied_offset_ms = diff[31:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    due_count = 0;
    clock_on = 1'b0;
  end

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      clock_on = 1'b0;
      due_times.delete();
    end else begin
      // Compare a returned beat with the oldest prediction
      if (result_valid && !result_stall) begin
        if (due_times.size() == 0) begin
          $error("unexpected result beat: %h", result);
          errors++;
        end else begin
          want = due_times.pop_front();
          if (result.write_time !== want.write_time) begin
            $error("write_time: expected %0d, got %0d", want.write_time, result.write_time);
            errors++;
          end
          if (result.new_time_bcd !== want.new_time_bcd) begin
            $error("new_time_bcd: expected %h, got %h", want.new_time_bcd,
                   result.new_time_bcd);
            errors++;
          end
          if (result.applied_offset_ms !== want.applied_offset_ms) begin
            $error("applied_offset_ms: expected %0d, got %0d", want.applied_offset_ms,
                   result.applied_offset_ms);
            errors++;
          end
        end
      end
      // Predict each accepted item
      if (item_valid && !item_stall) due_times.push_back(shifted_time(item, clock_on));
      if (cfg_valid && cfg_ready) clock_on = cfg_data;
    end
    due_count = due_times.size();
  end

endmodule

/* verif/tb.sv */
// Testbench top for bcd_time_of_day_shift_core: clock, reset, stimulus, stalls and verdict.
// Depends on bcdtod_pkg, the core and bcdtod_checker.
`timescale 1ns / 1ps

module tb;
  import bcdtod_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 80;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_beat_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_beat_t result;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  int errors;
  int due_count;
  int quiet = 0;
  bit burst = 1'b0;
  bit squeeze = 1'b0;
  logic moved;

  bcd_time_of_day_shift_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  bcdtod_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .due_count    (due_count)
  );

  always #6 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_beat_t beat(logic [22:0] t, logic [7:0] ss, logic [31:0] sh);
    in_beat_t b;
    b.time_bcd = t;
    b.subsecond_down = ss;
    b.offset_ms = sh;
    return b;
  endfunction

  // Well-formed time mostly, raw bits sometimes; shifts of every size
  function automatic in_beat_t random_item();
    in_beat_t b;
    int h, m, s, pick;
    h = $urandom_range(0, 23);
    m = $urandom_range(0, 59);
    s = $urandom_range(0, 59);
    b.time_bcd = {1'b0, 2'(h / 10), 4'(h % 10), 1'b0, 3'(m / 10), 4'(m % 10),
                  1'b0, 3'(s / 10), 4'(s % 10)};
    if ($urandom_range(0, 9) == 0) b.time_bcd = 23'($urandom);
    b.subsecond_down = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) b.offset_ms = $urandom_range(0, 3000);
    else if (pick < 70) b.offset_ms = $urandom_range(0, 172800000);
    else if (pick < 95) b.offset_ms = $urandom;
    else b.offset_ms = '0;
    if (pick < 70 && $urandom_range(0, 1)) b.offset_ms = -b.offset_ms;
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_item(in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= b;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain_items();
    item_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
  endtask

  // Write clock_ready once the core is empty
  task automatic set_clock_ready(bit on);
    drain_items();
    @(posedge clk);
    cfg_data <= on;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      burst = (i % 100) < 25;
      send_item(random_item());
    end
    burst = 1'b0;
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off
  initial begin : receiver
    int n;
    forever begin
      if (squeeze) begin
        result_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else if (burst) begin
        result_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          result_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  assign moved = (item_valid && !item_stall) || (result_valid && !result_stall) ||
                 (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (rst || moved) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Clock not ready yet: nothing is shifted
    send_item(beat(23'h123456, 8'd10, 32'd5000));
    send_item(beat(23'h7FFFFF, 8'd0, 32'sh80000000));
    set_clock_ready(1'b1);

    // Zero shift, rounding at the edges, wrap both ways, extreme shifts
    send_item(beat(23'h000000, 8'd255, 32'd0));
    send_item(beat(23'h000000, 8'd255, 32'd1));
    send_item(beat(23'h000000, 8'd255, -32'sd1));
    send_item(beat(23'h000000, 8'd255, -32'sd501));
    send_item(beat(23'h000000, 8'd255, -32'sd1501));
    send_item(beat(23'h235959, 8'd0, 32'd1000));
    send_item(beat(23'h235959, 8'd255, 32'd500));
    send_item(beat(23'h123456, 8'd128, 32'sh7FFFFFFF));
    send_item(beat(23'h123456, 8'd128, 32'sh80000000));
    // Non-decimal digits and the unused bits
    send_item(beat(23'h7FFFFF, 8'd0, 32'd1));
    send_item(beat(23'h7FFFFF, 8'd255, -32'sd1));
    send_item(beat(23'h3F7F7F, 8'd0, -32'sd12345));
    send_item(beat(23'h408080, 8'd77, 32'd60000));
    // Negative sums that truncate toward zero, and whole-day shifts
    send_item(beat(23'h000000, 8'd0, -32'sd999));
    send_item(beat(23'h000001, 8'd255, -32'sd1000));
    send_item(beat(23'h000000, 8'd255, -32'sd86400000));
    send_item(beat(23'h120000, 8'd0, 32'd2073600000));
    send_item(beat(23'h095959, 8'd1, 32'd2000));

    // Fill the core while the result side holds off
    drain_items();
    squeeze = 1'b1;
    burst = 1'b1;
    for (int i = 0; i < 60; i++) send_item(random_item());
    burst = 1'b0;
    send_random(340);

    set_clock_ready(1'b0);
    send_random(80);
    set_clock_ready(1'b1);
    send_random(370);

    // Let the last results out, then give the verdict
    drain_items();
    repeat (NUM_STAGES + 4) @(posedge clk);
    if (errors == 0 && due_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
